>>> design/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Types, codes and defaults shared by the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned MAX_HANDLES_DEF = 1024;
  localparam int unsigned SERIAL_BITS_DEF = 16;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned SERIAL_W = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOREIGN    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_ID      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_STALE      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     handle_id;
    logic [SERIAL_W-1:0] handle_serial;
    logic                same_owner;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     out_id;
    logic [SERIAL_W-1:0] out_serial;
    logic                handle_valid;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

>>> design/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Issues, retires and checks id/serial handles; serials and the free stack
// live in two RAMs, counters in flops.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  in      | in_valid_i / in_ready_o          | gha_pkg::req_t in_data_i
//  out     | out_valid_o / out_ready_i        | gha_pkg::rsp_t out_data_o
//
//  Each request is handled in ST_IDLE, where the transfer cycle issues the serial RAM
//  and free stack RAM reads, then in ST_EXEC, which commits the read-modify-write.
//  A new request is taken only once the previous one has committed.
//  The commit waits while the output register holds an untaken result.
//  Reset clears the counters, the state and the output valid flag; RAM contents are never cleared.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int unsigned MAX_HANDLES = gha_pkg::MAX_HANDLES_DEF,
  parameter int unsigned SERIAL_BITS = gha_pkg::SERIAL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gha_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gha_pkg::rsp_t out_data_o
);
  import gha_pkg::*;

  localparam int unsigned IDW   = $clog2(MAX_HANDLES);
  localparam int unsigned CW    = $clog2(MAX_HANDLES + 1);
  localparam int unsigned CMPW  = (CW > ID_W) ? CW : ID_W;
  localparam int unsigned SB    = SERIAL_BITS;
  localparam int unsigned STK_W = IDW + SB;

  state_e         state_q, state_d;
  req_t           req_q;
  rsp_t           out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic [CW-1:0]  free_cnt_q, free_cnt_d;
  logic [CW-1:0]  issued_q, issued_d;

  logic           accept, commit, out_free;

  logic           ser_we;
  logic [IDW-1:0] ser_waddr;
  logic [SB-1:0]  ser_wdata;
  logic [SB-1:0]  ser_rdata;
  logic           stk_we;
  logic [STK_W-1:0] stk_wdata;
  logic [STK_W-1:0] stk_rdata;
  logic [CW-1:0]  stk_top_cnt;

  logic [IDW-1:0] top_id, id_a;
  logic [SB-1:0]  top_ser, ser_m, ser_n;
  logic           id_ok;
  rsp_t           rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: commit     = out_free;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign stk_top_cnt = CW'(free_cnt_q - CW'(1));

  gha_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_HANDLES)
  ) u_serial_ram (
    .clk_i   (clk_i),
    .we_i    (ser_we),
    .waddr_i (ser_waddr),
    .wdata_i (ser_wdata),
    .re_i    (accept),
    .raddr_i (IDW'(in_data_i.handle_id)),
    .rdata_o (ser_rdata)
  );

  gha_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_HANDLES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_cnt_q[IDW-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (accept),
    .raddr_i (stk_top_cnt[IDW-1:0]),
    .rdata_o (stk_rdata)
  );

  assign top_id  = stk_rdata[STK_W-1:SB];
  assign top_ser = stk_rdata[SB-1:0];
  assign id_a    = IDW'(req_q.handle_id);
  assign ser_m   = SB'(req_q.handle_serial);
  assign ser_n   = SB'(ser_m + SB'(1));
  assign id_ok   = CMPW'(req_q.handle_id) < CMPW'(issued_q);

  // request evaluation
  always_comb begin
    rsp.out_id       = req_q.handle_id;
    rsp.out_serial   = SERIAL_W'(ser_m);
    rsp.handle_valid = 1'b0;
    rsp.status       = STATUS_OK;
    ser_we           = 1'b0;
    ser_waddr        = id_a;
    ser_wdata        = ser_n;
    stk_we           = 1'b0;
    stk_wdata        = {id_a, ser_n};
    free_cnt_d       = free_cnt_q;
    issued_d         = issued_q;
    case (req_q.mode)
      MODE_CREATE: begin
        if (free_cnt_q != '0) begin
          free_cnt_d     = stk_top_cnt;
          ser_we         = 1'b1;
          ser_waddr      = top_id;
          ser_wdata      = top_ser;
          rsp.out_id     = ID_W'(top_id);
          rsp.out_serial = SERIAL_W'(top_ser);
        end else if (issued_q != CW'(MAX_HANDLES)) begin
          issued_d       = CW'(issued_q + CW'(1));
          ser_we         = 1'b1;
          ser_waddr      = issued_q[IDW-1:0];
          ser_wdata      = SB'(1);
          rsp.out_id     = ID_W'(issued_q);
          rsp.out_serial = SERIAL_W'(1);
        end else begin
          rsp.out_id     = '0;
          rsp.out_serial = '0;
          rsp.status     = STATUS_TABLE_FULL;
        end
      end
      MODE_REMOVE: begin
        if (!req_q.same_owner) begin
          rsp.status = STATUS_FOREIGN;
        end else if (!id_ok) begin
          rsp.status = STATUS_NO_ID;
        end else if (free_cnt_q == CW'(MAX_HANDLES)) begin
          rsp.out_serial = SERIAL_W'(ser_n);
          rsp.status     = STATUS_STACK_FULL;
        end else begin
          rsp.out_serial = SERIAL_W'(ser_n);
          ser_we         = 1'b1;
          stk_we         = 1'b1;
          free_cnt_d     = CW'(free_cnt_q + CW'(1));
        end
      end
      MODE_CHECK: begin
        if (!req_q.same_owner) begin
          rsp.status = STATUS_FOREIGN;
        end else if (!id_ok) begin
          rsp.status = STATUS_NO_ID;
        end else if (ser_rdata != ser_m) begin
          rsp.status = STATUS_STALE;
        end else begin
          rsp.handle_valid = 1'b1;
        end
      end
      default: rsp.status = STATUS_OK;
    endcase
    if (!commit) begin
      ser_we     = 1'b0;
      stk_we     = 1'b0;
      free_cnt_d = free_cnt_q;
      issued_d   = issued_q;
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit) begin
      out_d       = rsp;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      free_cnt_q  <= '0;
      issued_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      free_cnt_q  <= free_cnt_d;
      issued_q    <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks for the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module gha_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input gha_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input gha_pkg::rsp_t out_data_o
);
  import gha_pkg::*;

  // held result stays put until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted back to back");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.handle_valid |-> out_data_o.status == STATUS_OK)
    else $error("valid handle with error status");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_TABLE_FULL
      |-> out_data_o.out_id == '0 && out_data_o.out_serial == '0)
    else $error("table full result not zeroed");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_scoreboard
// Watches both channels of the handle allocator, keeps its own copy of the
// serial table, free stack and counters, and compares every result transfer
// field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module gha_scoreboard #(
  parameter int unsigned MAX_HANDLES = gha_pkg::MAX_HANDLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  gha_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  gha_pkg::rsp_t out_data_i,
  output int            fail_cnt_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  logic [SERIAL_W-1:0] live_serial [MAX_HANDLES];
  logic [ID_W-1:0]     free_id     [MAX_HANDLES];
  logic [SERIAL_W-1:0] free_serial [MAX_HANDLES];
  int   free_top   = 0;
  int   issued_ids = 0;
  int   fails      = 0;
  int   due_cnt    = 0;
  rsp_t answers_due [$];

  assign fail_cnt_o = fails;
  assign pending_o  = due_cnt;

  function automatic rsp_t alloc_answer(input req_t r);
    rsp_t                a;
    logic [SERIAL_W-1:0] bumped;
    a            = '0;
    a.out_id     = r.handle_id;
    a.out_serial = r.handle_serial;
    a.status     = STATUS_OK;
    bumped       = r.handle_serial + 1'b1;
    case (r.mode)
      MODE_CREATE: begin
        if (free_top > 0) begin
          free_top--;
          a.out_id     = free_id[free_top];
          a.out_serial = free_serial[free_top];
          live_serial[a.out_id] = a.out_serial;
        end else if (issued_ids < MAX_HANDLES) begin
          a.out_id     = ID_W'(issued_ids);
          a.out_serial = SERIAL_W'(1);
          live_serial[issued_ids] = SERIAL_W'(1);
          issued_ids++;
        end else begin
          a.out_id     = '0;
          a.out_serial = '0;
          a.status     = STATUS_TABLE_FULL;
        end
      end
      MODE_REMOVE: begin
        if (!r.same_owner) begin
          a.status = STATUS_FOREIGN;
        end else if (r.handle_id >= issued_ids) begin
          a.status = STATUS_NO_ID;
        end else if (free_top >= MAX_HANDLES) begin
          a.out_serial = bumped;
          a.status     = STATUS_STACK_FULL;
        end else begin
          free_id[free_top]     = r.handle_id;
          free_serial[free_top] = bumped;
          free_top++;
          live_serial[r.handle_id] = bumped;
          a.out_serial = bumped;
        end
      end
      MODE_CHECK: begin
        if (!r.same_owner) begin
          a.status = STATUS_FOREIGN;
        end else if (r.handle_id >= issued_ids) begin
          a.status = STATUS_NO_ID;
        end else if (live_serial[r.handle_id] != r.handle_serial) begin
          a.status = STATUS_STALE;
        end else begin
          a.handle_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic cmp_field(input string what, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        answers_due = {answers_due, alloc_answer(in_data_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %0h", $time, out_data_i);
          fails++;
        end else begin
          want = answers_due.pop_front();
          cmp_field("out_id", 32'(want.out_id), 32'(out_data_i.out_id));
          cmp_field("out_serial", 32'(want.out_serial), 32'(out_data_i.out_serial));
          cmp_field("handle_valid", 32'(want.handle_valid), 32'(out_data_i.handle_valid));
          cmp_field("status", 32'(want.status), 32'(out_data_i.status));
        end
      end
      due_cnt <= answers_due.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the generational handle allocator: a short
// directed pass over every mode and corner, then random traffic that fills
// the id table, then a mixed phase with a long output stall. Results are
// checked by gha_scoreboard.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int MIXED_ITEMS = 180;
  localparam int PHASE_CAP   = 4000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  req_t in_data   = '0;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;
  int   fail_cnt;
  int   pending_cnt;

  // handles seen so far, used to aim removes and checks at live entries
  logic [SERIAL_W-1:0] known_serial [MAX_HANDLES_DEF] = '{default: '0};
  int known_ids = 0;
  logic [MODE_W-1:0] modes_sent [$];

  int n_sent       = 0;
  int n_rcvd       = 0;
  int n_table_full = 0;
  int n_stack_full = 0;
  int n_valid_hits = 0;
  int cycle_cnt    = 0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  generational_handle_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  gha_scoreboard i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 30);
  endfunction

  // leftover share of the percentages is noise: any mode, any field values
  function automatic req_t make_req(input int p_create, input int p_remove, input int p_check);
    req_t r;
    int   roll;
    r.mode          = MODE_W'($urandom_range(0, 3));
    r.handle_id     = ID_W'($urandom);
    r.handle_serial = SERIAL_W'($urandom);
    r.same_owner    = 1'($urandom);
    roll            = $urandom_range(0, 99);
    if (roll < p_create) begin
      r.mode = MODE_CREATE;
    end else if (roll < p_create + p_remove + p_check) begin
      r.mode       = (roll < p_create + p_remove) ? MODE_REMOVE : MODE_CHECK;
      r.same_owner = ($urandom_range(0, 19) != 0);
      if (known_ids > 0) begin
        r.handle_id = ID_W'($urandom_range(0, known_ids - 1));
      end
      if ($urandom_range(0, 9) != 0) begin
        r.handle_serial = known_serial[r.handle_id];
      end
    end
    return r;
  endfunction

  task automatic send(input req_t r);
    int gap;
    gap = (n_sent % 256 >= 100 && n_sent % 256 < 140) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready);
    modes_sent = {modes_sent, r.mode};
    n_sent++;
  endtask

  task automatic send_fields(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                             input logic [SERIAL_W-1:0] serial, input logic own);
    req_t r;
    r.mode          = mode;
    r.handle_id     = id;
    r.handle_serial = serial;
    r.same_owner    = own;
    send(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(MODE_CREATE, '0, '0, 1'b1);
    send_fields(MODE_CREATE, '1, '1, 1'b0);
    send_fields(MODE_CREATE, '0, '0, 1'b1);
    send_fields(MODE_CHECK, 10'd0, 16'd1, 1'b1);
    send_fields(MODE_CHECK, 10'd1, '1, 1'b1);
    send_fields(MODE_CHECK, 10'd0, 16'd1, 1'b0);
    send_fields(MODE_CHECK, '1, '0, 1'b1);
    send_fields(MODE_REMOVE, 10'd1, 16'd1, 1'b0);
    send_fields(MODE_REMOVE, '1, '1, 1'b1);
    send_fields(MODE_REMOVE, 10'd2, '1, 1'b1);
    send_fields(MODE_CHECK, 10'd2, '0, 1'b1);
    send_fields(MODE_REMOVE, 10'd0, 16'd5, 1'b1);
    send_fields(MODE_CREATE, '0, '0, 1'b0);
    send_fields(MODE_CREATE, '0, '0, 1'b1);
    send_fields(MODE_CREATE, '0, '0, 1'b1);
    send_fields(MODE_CHECK, 10'd0, 16'd6, 1'b1);
    send_fields(MODE_UNUSED, '1, '1, 1'b1);
    send_fields(MODE_UNUSED, '0, '0, 1'b0);
    send_fields(MODE_REMOVE, 10'd3, '0, 1'b1);
    send_fields(MODE_CHECK, 10'd3, 16'd1, 1'b1);
    drain();

    // mostly creates until every id is out and creates hit the full table
    k = 0;
    while (n_table_full < 4 && k < PHASE_CAP) begin
      send(make_req(92, 3, 3));
      k++;
    end
    drain();

    hold_req = 1'b1;
    repeat (MIXED_ITEMS) send(make_req(35, 30, 25));
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests, got %0d results; %0d valid checks seen.",
             n_sent, n_rcvd, n_valid_hits);
    $display("Table-full answers: %0d, stack-full answers: %0d.", n_table_full, n_stack_full);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int gap;
    logic [MODE_W-1:0] m;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = (n_rcvd % 256 < 40) ? 0 : pick_gap();
      if (hold_req && !hold_done) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      n_rcvd++;
      if (modes_sent.size() > 0) begin
        m = modes_sent.pop_front();
      end else begin
        m = MODE_UNUSED;
      end
      if (out_data.status == STATUS_TABLE_FULL) n_table_full++;
      if (out_data.status == STATUS_STACK_FULL) n_stack_full++;
      if (out_data.handle_valid) n_valid_hits++;
      if (out_data.status == STATUS_OK && (m == MODE_CREATE || m == MODE_REMOVE)) begin
        known_serial[out_data.out_id] = out_data.out_serial;
        if (m == MODE_CREATE && out_data.out_id >= known_ids) begin
          known_ids = out_data.out_id + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

endmodule

>>> generational_handle_allocator.f
design/gha_pkg.sv
design/gha_ram.sv
design/generational_handle_allocator.sv
design/gha_checker.sv
tb/sv/gha_checker.sv
tb/sv/tb.sv
